@@ design/ljpf_pkg.sv @@
// Shared constants, register indexes and output saturation for the
// Lennard-Jones pair force pipeline. No dependencies.
`default_nettype none
package ljpf_pkg;

  localparam int unsigned MAGW = 62;
  localparam logic [MAGW-1:0] CAP = {MAGW{1'b1}};

  localparam logic [1:0] CFG_CUTOFF_SQ    = 2'd0;
  localparam logic [1:0] CFG_SIGMA_POW6   = 2'd1;
  localparam logic [1:0] CFG_FOUR_EPSILON = 2'd2;

  localparam logic [23:0] CUTOFF_SQ_RST    = 24'd1380719;
  localparam logic [23:0] SIGMA_POW6_RST   = 24'd840690;
  localparam logic [23:0] FOUR_EPSILON_RST = 24'd570425;

  function automatic logic [31:0] sat_out(input logic [MAGW-1:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      if (mag >= MAGW'(64'h8000_0000)) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'(~mag[31:0] + 32'd1);
      end
    end else begin
      if (mag > MAGW'(64'h7FFF_FFFF)) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = mag[31:0];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ design/ljpf_mulsat.sv @@
// Two-stage multiply, shift right and saturate to CAP, built from four
// registered 32x32 partial products. Depends on ljpf_pkg.
`default_nettype none
module ljpf_mulsat
  import ljpf_pkg::*;
#(
  parameter int unsigned AW = 62,
  parameter int unsigned BW = 62,
  parameter int unsigned SH = 32
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [AW-1:0]   a,
  input  wire logic [BW-1:0]   b,
  output logic      [MAGW-1:0] p
);

  logic [63:0]     a64, b64;
  logic [63:0]     p00_r, p01_r, p10_r, p11_r;
  logic [127:0]    full, shifted;
  logic [MAGW-1:0] p_nxt, p_r;

  assign a64 = 64'(a);
  assign b64 = 64'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= a64[31:0]  * b64[31:0];
      p01_r <= a64[31:0]  * b64[63:32];
      p10_r <= a64[63:32] * b64[31:0];
      p11_r <= a64[63:32] * b64[63:32];
    end
  end

  always_comb begin
    full = {64'd0, p00_r} + ({64'd0, p01_r} << 32) + ({64'd0, p10_r} << 32)
         + {p11_r, 64'd0};
    shifted = full >> SH;
    if (shifted[127:MAGW] != '0) begin
      p_nxt = CAP;
    end else begin
      p_nxt = shifted[MAGW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

@@ design/lennard_jones_pair_force.sv @@
// Lennard-Jones 12-6 pair force pipeline: top level. Depends on ljpf_pkg
// and ljpf_mulsat.
//
// Takes one pair displacement per cycle unless the output stalls and
// returns force, energy and xx virial through an output register; the
// reciprocal of r^2 is a 64-stage restoring divider, one quotient bit per
// stage, and products run through registered multiply units. An output
// stall holds the whole pipeline; in_tready is out_tready or output empty.
`default_nettype none
module lennard_jones_pair_force
  import ljpf_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // dx, dy, dz
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // force_x, force_y, force_z, pair_energy, pair_virial
  output logic [159:0]                               out_tdata,
  // in_range
  output logic                                       out_tuser,
  input  wire logic                                  cfg_we,
  input  wire logic [1:0]                            cfg_addr,
  input  wire logic [23:0]                           cfg_wdata
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned SQW  = 2 * CW;
  localparam int unsigned R2W  = (2 * CW + 2 > 64) ? 64 : 2 * CW + 2;
  localparam int unsigned DW   = 40;
  localparam int unsigned NDIV = 64;
  localparam int unsigned NSD  = 15;
  localparam int unsigned NV   = 3 + NDIV + NSD;

  typedef struct packed {
    logic           rng;
    logic           near_zero;
    logic [2:0]     neg;
    logic [CW-1:0]  mx, my, mz;
    logic [SQW-1:0] dx2;
    logic [DW-1:0]  d;
  } dside_t;

  typedef struct packed {
    logic            rng;
    logic [2:0]      neg;
    logic [CW-1:0]   mx, my, mz;
    logic [SQW-1:0]  dx2;
    logic [MAGW-1:0] inv2;
    logic            tneg;
    logic            dneg;
    logic [MAGW:0]   dmag;
    logic [MAGW-1:0] emag;
    logic [MAGW-1:0] p4;
  } pside_t;

  logic [23:0] cutoff_sq_r, sigma_pow6_r, four_epsilon_r;
  logic        adv;
  logic [NV-1:0] vld_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_sq_r    <= CUTOFF_SQ_RST;
      sigma_pow6_r   <= SIGMA_POW6_RST;
      four_epsilon_r <= FOUR_EPSILON_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CUTOFF_SQ:    cutoff_sq_r    <= cfg_wdata;
        CFG_SIGMA_POW6:   sigma_pow6_r   <= cfg_wdata;
        CFG_FOUR_EPSILON: four_epsilon_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NV-2:0], in_tvalid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // stage A: magnitude and sign
  logic [CW-1:0] a_mag_nxt [3];
  logic [2:0]    a_neg_nxt;
  logic [CW-1:0] a_mag_r [3];
  logic [2:0]    a_neg_r;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      a_neg_nxt[m] = in_tdata[m*CW + CW - 1];
      a_mag_nxt[m] = a_neg_nxt[m] ? CW'(~in_tdata[m*CW +: CW] + 1'b1)
                                  : in_tdata[m*CW +: CW];
    end
  end

  // stage B: squares
  logic [SQW-1:0] b_sq_r [3];
  logic [CW-1:0]  b_mag_r [3];
  logic [2:0]     b_neg_r;

  // stage C: r^2, range check
  logic [R2W-1:0] r2;
  dside_t         c_nxt, c_r;

  always_comb begin
    r2 = R2W'(b_sq_r[0]) + R2W'(b_sq_r[1]) + R2W'(b_sq_r[2]);
    c_nxt.rng       = (r2 != '0) && (r2 <= R2W'({cutoff_sq_r, 16'd0}));
    c_nxt.near_zero = (r2 <= R2W'(4));
    c_nxt.neg       = b_neg_r;
    c_nxt.mx        = b_mag_r[0];
    c_nxt.my        = b_mag_r[1];
    c_nxt.mz        = b_mag_r[2];
    c_nxt.dx2       = b_sq_r[0];
    c_nxt.d         = DW'(r2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag_r <= a_mag_nxt;
      a_neg_r <= a_neg_nxt;
      for (int m = 0; m < 3; m++) begin
        b_sq_r[m] <= a_mag_r[m] * a_mag_r[m];
      end
      b_mag_r <= a_mag_r;
      b_neg_r <= a_neg_r;
      c_r     <= c_nxt;
    end
  end

  // divider: floor(2^64 / r^2), one bit per stage
  logic [DW-1:0]   dv_rem_r [NDIV];
  logic [MAGW-1:0] dv_quo_r [NDIV];
  dside_t          dv_side_r [NDIV];

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    logic [DW-1:0]   rem_in;
    logic [MAGW-1:0] quo_in;
    dside_t          side_in;
    logic [DW:0]     rem_sh;
    logic            qbit;
    logic [DW-1:0]   rem_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = DW'(1);
      assign quo_in  = '0;
      assign side_in = c_r;
    end else begin : g_rest
      assign rem_in  = dv_rem_r[i-1];
      assign quo_in  = dv_quo_r[i-1];
      assign side_in = dv_side_r[i-1];
    end

    always_comb begin
      rem_sh  = {rem_in, 1'b0};
      qbit    = rem_sh >= {1'b0, side_in.d};
      rem_nxt = qbit ? DW'(rem_sh - {1'b0, side_in.d}) : rem_sh[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[i]  <= rem_nxt;
        dv_quo_r[i]  <= {quo_in[MAGW-2:0], qbit};
        dv_side_r[i] <= side_in;
      end
    end
  end

  logic [MAGW-1:0] inv2_c;
  assign inv2_c = dv_side_r[NDIV-1].near_zero ? CAP : dv_quo_r[NDIV-1];

  // product chain
  logic [MAGW-1:0] inv4, inv6, q, e1, p1, emag, p2, p3, fmx, fmy, fmz, vmag;
  logic [MAGW-1:0] tmag;
  logic [MAGW:0]   q2;
  logic [MAGW+2:0] p6;
  pside_t          sd_nxt [NSD];
  pside_t          sd_r [NSD];

  ljpf_mulsat #(.AW(MAGW), .BW(MAGW), .SH(32)) u_inv4 (
    .clk(clk), .en(adv), .a(inv2_c), .b(inv2_c), .p(inv4));
  ljpf_mulsat #(.AW(MAGW), .BW(MAGW), .SH(32)) u_inv6 (
    .clk(clk), .en(adv), .a(inv4), .b(sd_r[1].inv2), .p(inv6));
  ljpf_mulsat #(.AW(24), .BW(MAGW), .SH(16)) u_q (
    .clk(clk), .en(adv), .a(sigma_pow6_r), .b(inv6), .p(q));
  ljpf_mulsat #(.AW(MAGW), .BW(MAGW), .SH(32)) u_e1 (
    .clk(clk), .en(adv), .a(q), .b(tmag), .p(e1));
  ljpf_mulsat #(.AW(MAGW), .BW(MAGW), .SH(32)) u_p1 (
    .clk(clk), .en(adv), .a(q), .b(sd_r[5].inv2), .p(p1));
  ljpf_mulsat #(.AW(MAGW), .BW(24), .SH(40)) u_em (
    .clk(clk), .en(adv), .a(e1), .b(four_epsilon_r), .p(emag));
  ljpf_mulsat #(.AW(MAGW), .BW(MAGW+1), .SH(32)) u_p2 (
    .clk(clk), .en(adv), .a(p1), .b(sd_r[7].dmag), .p(p2));
  ljpf_mulsat #(.AW(MAGW), .BW(24), .SH(24)) u_p3 (
    .clk(clk), .en(adv), .a(p2), .b(four_epsilon_r), .p(p3));
  ljpf_mulsat #(.AW(MAGW), .BW(CW), .SH(32)) u_fx (
    .clk(clk), .en(adv), .a(sd_r[12].p4), .b(sd_r[12].mx), .p(fmx));
  ljpf_mulsat #(.AW(MAGW), .BW(CW), .SH(32)) u_fy (
    .clk(clk), .en(adv), .a(sd_r[12].p4), .b(sd_r[12].my), .p(fmy));
  ljpf_mulsat #(.AW(MAGW), .BW(CW), .SH(32)) u_fz (
    .clk(clk), .en(adv), .a(sd_r[12].p4), .b(sd_r[12].mz), .p(fmz));
  ljpf_mulsat #(.AW(MAGW), .BW(SQW), .SH(47)) u_vir (
    .clk(clk), .en(adv), .a(sd_r[12].p4), .b(sd_r[12].dx2), .p(vmag));

  always_comb begin
    tmag = (q < MAGW'(64'h1_0000_0000)) ? MAGW'(64'h1_0000_0000) - q
                                        : q - MAGW'(64'h1_0000_0000);
    q2   = {q, 1'b0};
    p6   = {1'b0, p3, 2'b00} + {2'b00, p3, 1'b0};

    sd_nxt[0]      = '0;
    sd_nxt[0].rng  = dv_side_r[NDIV-1].rng;
    sd_nxt[0].neg  = dv_side_r[NDIV-1].neg;
    sd_nxt[0].mx   = dv_side_r[NDIV-1].mx;
    sd_nxt[0].my   = dv_side_r[NDIV-1].my;
    sd_nxt[0].mz   = dv_side_r[NDIV-1].mz;
    sd_nxt[0].dx2  = dv_side_r[NDIV-1].dx2;
    sd_nxt[0].inv2 = inv2_c;
    for (int k = 1; k < NSD; k++) begin
      sd_nxt[k] = sd_r[k-1];
    end
    sd_nxt[6].tneg  = q < MAGW'(64'h1_0000_0000);
    sd_nxt[6].dneg  = q2 < (MAGW+1)'(64'h1_0000_0000);
    sd_nxt[6].dmag  = sd_nxt[6].dneg ? (MAGW+1)'(64'h1_0000_0000) - q2
                                     : q2 - (MAGW+1)'(64'h1_0000_0000);
    sd_nxt[10].emag = emag;
    sd_nxt[12].p4   = (p6 > (MAGW+3)'(CAP)) ? CAP : p6[MAGW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r <= sd_nxt;
    end
  end

  // output register
  pside_t      fin;
  logic [31:0] fx_nxt, fy_nxt, fz_nxt, en_nxt, vr_nxt;
  logic [159:0] tdata_r;
  logic         tuser_r;

  always_comb begin
    fin    = sd_r[NSD-1];
    fx_nxt = fin.rng ? sat_out(fmx, fin.dneg ^ fin.neg[0]) : '0;
    fy_nxt = fin.rng ? sat_out(fmy, fin.dneg ^ fin.neg[1]) : '0;
    fz_nxt = fin.rng ? sat_out(fmz, fin.dneg ^ fin.neg[2]) : '0;
    en_nxt = fin.rng ? sat_out(fin.emag, fin.tneg) : '0;
    vr_nxt = fin.rng ? sat_out(vmag, fin.dneg) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tdata_r <= {vr_nxt, en_nxt, fz_nxt, fy_nxt, fx_nxt};
      tuser_r <= fin.rng;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

  a_zero_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("out-of-range result carries non-zero data");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(vld_r) && $stable(sd_r[NSD-1])))
    else $error("pipeline moved during output stall");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && vld_r == '0))
    else $error("valid bits survive reset");

endmodule
`default_nettype wire
